// ===== rtl/rsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rsi_pkg: shared definitions of the RGBA span interpolator
// Default parameters, channel indexes, and the control structs that run
// between the sequencer, the channel lanes and the output merge.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int unsigned MaxSpanDef   = 64;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned CoordBitsDef = 12;

  localparam int unsigned ChanBits = 8;
  localparam int unsigned IdxBits  = 6;
  localparam int unsigned NumChan  = 4;

  // Lane order inside the packed channel vectors
  localparam int unsigned ChRed   = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 2;
  localparam int unsigned ChAlpha = 3;

  typedef logic [ChanBits-1:0] chan_t;

  typedef struct packed {
    logic start;
    logic advance;
  } lane_ctrl_t;

  typedef struct packed {
    logic               valid;
    logic [IdxBits-1:0] step_index;
    logic               last;
    logic               truncated;
  } beat_ctrl_t;

endpackage

// ===== rtl/rsi_if.sv =====
// ----------------------------------------------------------------------------
// rsi_if: span request and pixel result channels
// Valid/ready channels; a beat moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface rsi_span_if import rsi_pkg::*; #(
  parameter int unsigned CoordBits = CoordBitsDef
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] start_pos;
  logic signed [CoordBits-1:0] end_pos;
  logic [ChanBits-1:0]         start_red;
  logic [ChanBits-1:0]         start_green;
  logic [ChanBits-1:0]         start_blue;
  logic [ChanBits-1:0]         start_alpha;
  logic [ChanBits-1:0]         end_red;
  logic [ChanBits-1:0]         end_green;
  logic [ChanBits-1:0]         end_blue;
  logic [ChanBits-1:0]         end_alpha;

  modport source (
    output valid, start_pos, end_pos, start_red, start_green, start_blue, start_alpha,
           end_red, end_green, end_blue, end_alpha,
    input  ready
  );
  modport sink (
    input  valid, start_pos, end_pos, start_red, start_green, start_blue, start_alpha,
           end_red, end_green, end_blue, end_alpha,
    output ready
  );
endinterface

interface rsi_pix_if import rsi_pkg::*;;
  logic               valid;
  logic               ready;
  logic [IdxBits-1:0] step_index;
  logic [ChanBits-1:0] red;
  logic [ChanBits-1:0] green;
  logic [ChanBits-1:0] blue;
  logic [ChanBits-1:0] alpha;
  logic               last;
  logic               truncated;

  modport source (
    output valid, step_index, red, green, blue, alpha, last, truncated,
    input  ready
  );
  modport sink (
    input  valid, step_index, red, green, blue, alpha, last, truncated,
    output ready
  );
endinterface

// ===== rtl/rsi_lane.sv =====
// ----------------------------------------------------------------------------
// rsi_lane: one color channel of the span interpolator
// Restoring divider for the fixed-point slope, one quotient bit per cycle,
// then an accumulator that steps by the slope once per emitted beat.
// ----------------------------------------------------------------------------
module rsi_lane import rsi_pkg::*; #(
  parameter int unsigned FracBits  = FracBitsDef,
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lane_ctrl_t           ctrl_i,
  input  chan_t                start_chan_i,
  input  chan_t                end_chan_i,
  input  logic [CoordBits-1:0] dist_i,
  output logic                 busy_o,
  output chan_t                value_o
);

  localparam int unsigned QuoBits = ChanBits + FracBits;
  localparam int unsigned AccBits = QuoBits + 2;
  localparam int unsigned IntBits = AccBits - 1 - FracBits;
  localparam int unsigned CntBits = $clog2(QuoBits + 1);

  logic                 busy_q;
  logic [CntBits-1:0]   cnt_q;
  logic [CoordBits-1:0] rem_q, rem_d;
  logic [QuoBits-1:0]   quo_q;
  logic [CoordBits-1:0] div_q;
  logic                 neg_q;
  logic [AccBits-1:0]   acc_q;

  logic [CoordBits:0]   trial;
  logic [CoordBits:0]   trial_sub;
  logic                 trial_ge;
  chan_t                mag;
  logic [AccBits-1:0]   slope;
  logic [IntBits-1:0]   int_part;

  assign mag = (end_chan_i >= start_chan_i) ? end_chan_i - start_chan_i
                                            : start_chan_i - end_chan_i;

  // Shift in the next dividend bit, subtract the distance where it fits
  assign trial     = {rem_q, quo_q[QuoBits-1]};
  assign trial_ge  = trial >= {1'b0, div_q};
  assign trial_sub = trial - {1'b0, div_q};
  assign rem_d     = trial_ge ? trial_sub[CoordBits-1:0] : trial[CoordBits-1:0];

  assign slope = neg_q ? AccBits'(0) - {2'b00, quo_q} : {2'b00, quo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= CntBits'(QuoBits);
    end else if (busy_q) begin
      busy_q <= (cnt_q != CntBits'(1));
      cnt_q  <= cnt_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      div_q <= dist_i;
      rem_q <= '0;
      quo_q <= {mag, {FracBits{1'b0}}};
      neg_q <= end_chan_i < start_chan_i;
      acc_q <= {2'b00, start_chan_i, {FracBits{1'b0}}};
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[QuoBits-2:0], trial_ge};
    end else if (ctrl_i.advance) begin
      acc_q <= acc_q + slope;
    end
  end

  // Truncate to the integer part, clamp to the channel range
  assign int_part = acc_q[AccBits-2:FracBits];

  always_comb begin
    if (acc_q[AccBits-1]) begin
      value_o = '0;
    end else if (int_part[IntBits-1:ChanBits] != '0) begin
      value_o = '1;
    end else begin
      value_o = int_part[ChanBits-1:0];
    end
  end

  assign busy_o = busy_q;

  a_no_start_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start || ctrl_i.advance |-> !busy_q)
    else $error("lane restarted or stepped during division");

endmodule

// ===== rtl/rsi_merge.sv =====
// ----------------------------------------------------------------------------
// rsi_merge: output stage of the span interpolator
// Gather the lane values with the step tag into one registered beat.
// ----------------------------------------------------------------------------
module rsi_merge import rsi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  beat_ctrl_t          beat_i,
  input  chan_t [NumChan-1:0] chan_i,
  output logic                space_o,
  rsi_pix_if.source           pix_o
);

  logic                valid_q;
  logic [IdxBits-1:0]  step_index_q;
  chan_t [NumChan-1:0] chan_q;
  logic                last_q;
  logic                truncated_q;

  assign space_o = !valid_q || pix_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (beat_i.valid) begin
      valid_q <= 1'b1;
    end else if (pix_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i.valid) begin
      step_index_q <= beat_i.step_index;
      chan_q       <= chan_i;
      last_q       <= beat_i.last;
      truncated_q  <= beat_i.truncated;
    end
  end

  assign pix_o.valid      = valid_q;
  assign pix_o.step_index = step_index_q;
  assign pix_o.red        = chan_q[ChRed];
  assign pix_o.green      = chan_q[ChGreen];
  assign pix_o.blue       = chan_q[ChBlue];
  assign pix_o.alpha      = chan_q[ChAlpha];
  assign pix_o.last       = last_q;
  assign pix_o.truncated  = truncated_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i.valid |-> space_o)
    else $error("beat pushed into a held output register");

endmodule

// ===== rtl/rgba_span_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// rgba_span_interpolator_core: linear RGBA interpolation along one span
// Sequence: a span is taken, its four slopes are divided in parallel lanes,
//   and the beats then go out through the registered output merge.
// Throughput: one beat per cycle while pix_o is ready, up to MaxSpan beats; one
//   span is in work at a time, so the next span waits until the last beat.
// Reset: rst_ni clears the sequencer and the output valid at once; no sweep.
// ----------------------------------------------------------------------------
module rgba_span_interpolator_core import rsi_pkg::*; #(
  parameter int unsigned MaxSpan   = MaxSpanDef,
  parameter int unsigned FracBits  = FracBitsDef,
  parameter int unsigned CoordBits = CoordBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rsi_span_if.sink  span_i,
  rsi_pix_if.source pix_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  localparam logic [CoordBits-1:0] LastCap = CoordBits'(MaxSpan - 1);

  state_e             state_q;
  logic [IdxBits-1:0] step_q;
  logic [IdxBits-1:0] last_idx_q;
  logic               cut_q;

  logic [CoordBits:0]   diff;
  logic                 span_neg;
  logic [CoordBits-1:0] span_dist;
  logic                 cut_w;
  logic [IdxBits-1:0]   last_w;
  logic                 accept;

  lane_ctrl_t          lane_ctrl;
  beat_ctrl_t          beat;
  logic [NumChan-1:0]  lane_busy;
  chan_t [NumChan-1:0] lane_val;
  chan_t [NumChan-1:0] start_chan;
  chan_t [NumChan-1:0] end_chan;
  logic                space;

  // Span geometry: distance in coordinates, and the cut to MaxSpan beats
  assign diff      = {span_i.end_pos[CoordBits-1], span_i.end_pos}
                   - {span_i.start_pos[CoordBits-1], span_i.start_pos};
  assign span_neg  = diff[CoordBits];
  assign span_dist = diff[CoordBits-1:0];
  assign cut_w     = span_dist > LastCap;
  assign last_w    = cut_w ? IdxBits'(MaxSpan - 1) : span_dist[IdxBits-1:0];

  // Take a new span only when the lanes and the step counter are free
  assign span_i.ready = (state_q == ST_IDLE);
  assign accept       = span_i.valid && span_i.ready;

  assign start_chan[ChRed]   = span_i.start_red;
  assign start_chan[ChGreen] = span_i.start_green;
  assign start_chan[ChBlue]  = span_i.start_blue;
  assign start_chan[ChAlpha] = span_i.start_alpha;
  assign end_chan[ChRed]     = span_i.end_red;
  assign end_chan[ChGreen]   = span_i.end_green;
  assign end_chan[ChBlue]    = span_i.end_blue;
  assign end_chan[ChAlpha]   = span_i.end_alpha;

  // A reversed span is accepted and dropped without results.
  // Equal coordinates divide by zero; harmless, as only the start value is read.
  assign lane_ctrl.start   = accept && !span_neg;
  assign lane_ctrl.advance = beat.valid;

  // Emit one beat whenever the output register can take it
  assign beat.valid      = (state_q == ST_EMIT) && space;
  assign beat.step_index = step_q;
  assign beat.last       = (step_q == last_idx_q);
  assign beat.truncated  = cut_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      last_idx_q <= '0;
      cut_q      <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (lane_ctrl.start) begin
            last_idx_q <= last_w;
            cut_q      <= cut_w;
            step_q     <= '0;
            state_q    <= ST_DIV;
          end
        end
        ST_DIV: begin
          // Lanes share one divider length, so they finish together
          if (lane_busy == '0) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (beat.valid) begin
            step_q <= step_q + IdxBits'(1);
            if (beat.last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  for (genvar g = 0; g < NumChan; g++) begin : g_lane
    rsi_lane #(
      .FracBits  (FracBits),
      .CoordBits (CoordBits)
    ) u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (lane_ctrl),
      .start_chan_i (start_chan[g]),
      .end_chan_i   (end_chan[g]),
      .dist_i       (span_dist),
      .busy_o       (lane_busy[g]),
      .value_o      (lane_val[g])
    );
  end

  rsi_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (beat),
    .chan_i  (lane_val),
    .space_o (space),
    .pix_o   (pix_o)
  );

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> step_q <= last_idx_q)
    else $error("step counter ran past the span end");

  a_last_ends_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat.valid && beat.last |=> state_q == ST_IDLE)
    else $error("sequencer kept running after the last beat");

  a_lanes_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(lane_busy) == 0 || $countones(lane_busy) == NumChan)
    else $error("lanes out of step");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rgba_span_interpolator_core
// Sends span requests through the valid/ready request channel and checks
// every pixel beat against a fixed-point DDA predictor or a typed directed run.
// A short directed table comes first, then randomized spans with bursty
// requests and an irregular, sometimes long, pixel backpressure.
// ----------------------------------------------------------------------------
module testbench;
  import rsi_pkg::*;

  localparam int unsigned MaxSpan   = MaxSpanDef;
  localparam int unsigned FracBits  = FracBitsDef;
  localparam int unsigned CoordBits = CoordBitsDef;

  // Coordinates run over the full signed range of the request fields
  localparam int CoordMin = -(2 ** (CoordBits - 1));
  localparam int CoordMax = (2 ** (CoordBits - 1)) - 1;
  localparam int CoordSpan = 2 ** CoordBits;

  localparam int unsigned RandomSpans   = 255;
  localparam int unsigned HoldoffAt     = 40;
  localparam int unsigned HoldoffCycles = 600;
  // Slope division, output register and some margin
  localparam int unsigned DrainCycles   = FracBits + 8 + 2 + 30;
  localparam int unsigned CycleLimit    = 800_000;
  localparam int unsigned ReportLimit   = 10;
  localparam int unsigned NumDirRows    = 20;

  typedef struct packed {
    logic signed [CoordBits-1:0] start_pos;
    logic signed [CoordBits-1:0] end_pos;
    chan_t                       start_red;
    chan_t                       start_green;
    chan_t                       start_blue;
    chan_t                       start_alpha;
    chan_t                       end_red;
    chan_t                       end_green;
    chan_t                       end_blue;
    chan_t                       end_alpha;
  } span_t;

  typedef struct packed {
    logic [IdxBits-1:0] step_index;
    chan_t              red;
    chan_t              green;
    chan_t              blue;
    chan_t              alpha;
    logic               last;
    logic               truncated;
  } pixel_t;

  // One row of the directed table; a typed row carries its expected run
  // directly: n_beats pixels of the start colour, cut flag as given.
  typedef struct {
    span_t       span;
    bit          typed;
    int unsigned n_beats;
    bit          cut;
  } dir_row_t;

  typedef enum logic [1:0] {
    SINK_STEADY,
    SINK_CHOPPY,
    SINK_SLUGGISH
  } sink_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rsi_span_if #(.CoordBits(CoordBits)) span_bus ();
  rsi_pix_if                           pix_bus ();

  rgba_span_interpolator_core #(
    .MaxSpan  (MaxSpan),
    .FracBits (FracBits),
    .CoordBits(CoordBits)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .span_i(span_bus),
    .pix_o (pix_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pixels still owed by the block, oldest first
  pixel_t pixel_exp_q[$];

  int unsigned mismatch_count = 0;
  int unsigned beats_checked  = 0;
  int unsigned spans_sent     = 0;
  int unsigned empty_spans    = 0;
  int unsigned point_spans    = 0;
  int unsigned cut_spans      = 0;
  int unsigned cycle_count    = 0;
  bit          holdoff_req    = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Integer part of a fixed-point channel, clamped to the 8-bit range
  function automatic chan_t level_of(longint acc);
    longint whole;
    if (acc < 0) return '0;
    whole = acc >>> FracBits;
    if (whole > 255) return 8'hFF;
    return chan_t'(whole);
  endfunction

  function automatic pixel_t make_pixel(int unsigned k, chan_t r, chan_t g, chan_t b,
                                        chan_t a, bit last, bit cut);
    pixel_t px;
    px.step_index = k[IdxBits-1:0];
    px.red        = r;
    px.green      = g;
    px.blue       = b;
    px.alpha      = a;
    px.last       = last;
    px.truncated  = cut;
    return px;
  endfunction

  // Walk the span with one accumulator per channel and queue every pixel
  function automatic void predict_span_pixels(span_t s);
    int          p0;
    int          p1;
    int          span_dist;
    int unsigned count;
    bit          cut;
    longint      acc[NumChan];
    longint      slope[NumChan];
    longint      c0[NumChan];
    longint      c1[NumChan];
    p0 = s.start_pos;
    p1 = s.end_pos;
    if (p1 < p0) return;
    if (p1 == p0) begin
      pixel_exp_q.push_back(make_pixel(0, s.start_red, s.start_green, s.start_blue,
                                       s.start_alpha, 1'b1, 1'b0));
      return;
    end
    c0[ChRed]   = s.start_red;
    c0[ChGreen] = s.start_green;
    c0[ChBlue]  = s.start_blue;
    c0[ChAlpha] = s.start_alpha;
    c1[ChRed]   = s.end_red;
    c1[ChGreen] = s.end_green;
    c1[ChBlue]  = s.end_blue;
    c1[ChAlpha] = s.end_alpha;
    span_dist = p1 - p0;
    count     = span_dist + 1;
    cut       = 1'b0;
    if (count > MaxSpan) begin
      count = MaxSpan;
      cut   = 1'b1;
    end
    // Signed division truncates toward zero, as the slope needs
    for (int c = 0; c < NumChan; c++) begin
      acc[c]   = c0[c] <<< FracBits;
      slope[c] = ((c1[c] - c0[c]) <<< FracBits) / longint'(span_dist);
    end
    for (int unsigned k = 0; k < count; k++) begin
      pixel_exp_q.push_back(make_pixel(k, level_of(acc[ChRed]), level_of(acc[ChGreen]),
                                       level_of(acc[ChBlue]), level_of(acc[ChAlpha]),
                                       k + 1 == count, cut));
      for (int c = 0; c < NumChan; c++) acc[c] += slope[c];
    end
  endfunction

  // A typed directed row: a run of start-colour pixels, known at a glance
  function automatic void queue_typed_run(span_t s, int unsigned n, bit cut);
    for (int unsigned k = 0; k < n; k++) begin
      pixel_exp_q.push_back(make_pixel(k, s.start_red, s.start_green, s.start_blue,
                                       s.start_alpha, k + 1 == n, cut));
    end
  endfunction

  function automatic span_t mk_span(int p0, int p1, int sr, int sg, int sb, int sa,
                                    int er, int eg, int eb, int ea);
    span_t s;
    s.start_pos   = p0[CoordBits-1:0];
    s.end_pos     = p1[CoordBits-1:0];
    s.start_red   = sr[7:0];
    s.start_green = sg[7:0];
    s.start_blue  = sb[7:0];
    s.start_alpha = sa[7:0];
    s.end_red     = er[7:0];
    s.end_green   = eg[7:0];
    s.end_blue    = eb[7:0];
    s.end_alpha   = ea[7:0];
    return s;
  endfunction

  // Channel values lean toward the rails now and then
  function automatic int rand_level();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 0;
    if (pick == 1) return 255;
    return $urandom_range(0, 255);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  int unsigned burst_left = 0;

  // Offer one span and hold it until the block takes the beat
  task automatic drive_span(span_t s);
    span_bus.valid       <= 1'b1;
    span_bus.start_pos   <= s.start_pos;
    span_bus.end_pos     <= s.end_pos;
    span_bus.start_red   <= s.start_red;
    span_bus.start_green <= s.start_green;
    span_bus.start_blue  <= s.start_blue;
    span_bus.start_alpha <= s.start_alpha;
    span_bus.end_red     <= s.end_red;
    span_bus.end_green   <= s.end_green;
    span_bus.end_blue    <= s.end_blue;
    span_bus.end_alpha   <= s.end_alpha;
    do @(posedge clk_i); while (span_bus.ready !== 1'b1);
    spans_sent++;
    if (s.end_pos < s.start_pos) empty_spans++;
    else if (s.end_pos == s.start_pos) point_spans++;
    else if (int'(s.end_pos) - int'(s.start_pos) + 1 > MaxSpan) cut_spans++;
  endtask

  // Close a burst when it runs out, then idle for a random gap
  task automatic pace_requests();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30)
                                               : $urandom_range(1, 6);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        span_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Pixel side: backpressure
  // ---------------------------------------------------------------------------

  // Alternate steady, choppy and sluggish phases; once, on request, hold
  // ready low for a long stretch so the block backs up into the request side.
  initial begin : pixel_sink
    int unsigned phase_left;
    int unsigned holdoff_left;
    bit          holdoff_done;
    sink_mode_e  mode;
    phase_left   = 0;
    holdoff_left = 0;
    holdoff_done = 1'b0;
    mode         = SINK_STEADY;
    pix_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holdoff_req && !holdoff_done) begin
        holdoff_done = 1'b1;
        holdoff_left = HoldoffCycles;
      end
      if (holdoff_left != 0) begin
        holdoff_left--;
        pix_bus.ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode       = sink_mode_e'($urandom_range(0, 2));
          phase_left = $urandom_range(10, 150);
        end
        phase_left--;
        case (mode)
          SINK_STEADY:   pix_bus.ready <= 1'b1;
          SINK_CHOPPY:   pix_bus.ready <= 1'($urandom_range(0, 1));
          default:       pix_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel side: checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    pixel_t got;
    pixel_t want;
    if (rst_ni && pix_bus.valid === 1'b1 && pix_bus.ready === 1'b1) begin
      got.step_index = pix_bus.step_index;
      got.red        = pix_bus.red;
      got.green      = pix_bus.green;
      got.blue       = pix_bus.blue;
      got.alpha      = pix_bus.alpha;
      got.last       = pix_bus.last;
      got.truncated  = pix_bus.truncated;
      if (pixel_exp_q.size() == 0) begin
        // Flag a beat that no accepted span accounts for
        if (mismatch_count < ReportLimit)
          $display("%0t: unexpected pixel beat idx=%0d rgba=%02h%02h%02h%02h last=%0b cut=%0b",
                   $realtime, got.step_index, got.red, got.green, got.blue, got.alpha,
                   got.last, got.truncated);
        mismatch_count++;
      end else begin
        want = pixel_exp_q.pop_front();
        beats_checked++;
        if (got.step_index !== want.step_index || got.red !== want.red ||
            got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.last !== want.last ||
            got.truncated !== want.truncated) begin
          if (mismatch_count < ReportLimit) begin
            $display("%0t: pixel mismatch", $realtime);
            $display("  expected idx=%0d rgba=%02h %02h %02h %02h last=%0b cut=%0b",
                     want.step_index, want.red, want.green, want.blue, want.alpha,
                     want.last, want.truncated);
            $display("  actual   idx=%0d rgba=%02h %02h %02h %02h last=%0b cut=%0b",
                     got.step_index, got.red, got.green, got.blue, got.alpha,
                     got.last, got.truncated);
          end
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d pixels still owed", cycle_count,
             pixel_exp_q.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    dir_row_t    dir_rows[NumDirRows];
    span_t       s;
    int          p0;
    int          p1;
    int          span_len;
    int unsigned kind;
    int unsigned a;
    int unsigned b;
    int unsigned random_done;
    int unsigned random_offered;

    span_bus.valid       <= 1'b0;
    span_bus.start_pos   <= '0;
    span_bus.end_pos     <= '0;
    span_bus.start_red   <= '0;
    span_bus.start_green <= '0;
    span_bus.start_blue  <= '0;
    span_bus.start_alpha <= '0;
    span_bus.end_red     <= '0;
    span_bus.end_green   <= '0;
    span_bus.end_blue    <= '0;
    span_bus.end_alpha   <= '0;

    // Typed rows: single points, empty reversed spans and flat colour runs.
    // Everything else in the table goes through the predictor.
    dir_rows = '{
      // Single point: one start-colour pixel, marked last
      '{mk_span(0, 0, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE, 8'hF0), 1, 1, 0},
      '{mk_span(CoordMin, CoordMin, 255, 255, 255, 255, 0, 0, 0, 0), 1, 1, 0},
      '{mk_span(CoordMax, CoordMax, 0, 0, 0, 0, 255, 255, 255, 255), 1, 1, 0},
      // End below start: nothing comes out
      '{mk_span(5, 4, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA), 1, 0, 0},
      '{mk_span(CoordMax, CoordMin, 255, 0, 255, 0, 0, 255, 0, 255), 1, 0, 0},
      // Flat colour: exactly MaxSpan, one past it, and the widest span
      '{mk_span(0, MaxSpan - 1, 0, 0, 0, 0, 0, 0, 0, 0), 1, MaxSpan, 0},
      '{mk_span(0, MaxSpan, 8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'hA5, 8'h5A, 8'hC3, 8'h3C),
        1, MaxSpan, 1},
      '{mk_span(CoordMin, CoordMax, 255, 255, 255, 255, 255, 255, 255, 255), 1, MaxSpan, 1},
      // Ramps checked by prediction
      '{mk_span(0, 1, 0, 0, 0, 0, 255, 255, 255, 255), 0, 0, 0},
      '{mk_span(0, 1, 255, 255, 255, 255, 0, 0, 0, 0), 0, 0, 0},
      '{mk_span(CoordMin, CoordMin + 1, 0, 255, 17, 200, 255, 0, 200, 17), 0, 0, 0},
      '{mk_span(CoordMax - 1, CoordMax, 1, 2, 254, 128, 0, 3, 255, 127), 0, 0, 0},
      '{mk_span(10, 10 + MaxSpan - 1, 0, 0, 0, 0, 255, 255, 255, 255), 0, 0, 0},
      '{mk_span(0, MaxSpan - 2, 255, 255, 255, 255, 0, 0, 0, 0), 0, 0, 0},
      '{mk_span(CoordMin, CoordMax, 0, 255, 0, 255, 255, 0, 255, 0), 0, 0, 0},
      '{mk_span(100, 102, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'hAA, 8'h55, 8'hF0, 8'h0F), 0, 0, 0},
      '{mk_span(0, 2, 1, 0, 2, 255, 0, 1, 0, 254), 0, 0, 0},
      '{mk_span(-1, 0, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h7F, 8'h80, 8'hFE, 8'h01), 0, 0, 0},
      '{mk_span(-3, 4, 3, 200, 77, 0, 250, 9, 77, 7), 0, 0, 0},
      '{mk_span(CoordMin, CoordMin + 63, 255, 0, 128, 64, 0, 255, 129, 63), 0, 0, 0}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part
    foreach (dir_rows[i]) begin
      drive_span(dir_rows[i].span);
      if (dir_rows[i].typed) queue_typed_run(dir_rows[i].span, dir_rows[i].n_beats,
                                             dir_rows[i].cut);
      else predict_span_pixels(dir_rows[i].span);
      pace_requests();
    end

    // Random part: mostly short spans, some points, some long cut spans,
    // and reversed spans as noise (those do not count toward the total)
    random_done    = 0;
    random_offered = 0;
    while (random_done < RandomSpans) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        b  = $urandom_range(0, CoordSpan - 2);
        a  = $urandom_range(b + 1, CoordSpan - 1);
        p0 = int'(a) + CoordMin;
        p1 = int'(b) + CoordMin;
      end else if (kind < 22) begin
        p0 = int'($urandom_range(0, CoordSpan - 1)) + CoordMin;
        p1 = p0;
      end else if (kind < 92) begin
        span_len = $urandom_range(1, MaxSpan + 6);
        p0       = int'($urandom_range(0, CoordSpan - 1 - span_len)) + CoordMin;
        p1       = p0 + span_len;
      end else begin
        a  = $urandom_range(0, CoordSpan - 1);
        b  = $urandom_range(0, CoordSpan - 1);
        p0 = int'((a < b) ? a : b) + CoordMin;
        p1 = int'((a < b) ? b : a) + CoordMin;
      end
      s = mk_span(p0, p1, rand_level(), rand_level(), rand_level(), rand_level(),
                  rand_level(), rand_level(), rand_level(), rand_level());
      drive_span(s);
      predict_span_pixels(s);
      if (p1 >= p0) random_done++;
      random_offered++;
      // Hold the pixel side off while requests keep coming
      if (random_offered == HoldoffAt) holdoff_req = 1'b1;
      pace_requests();
    end
    span_bus.valid <= 1'b0;

    // Drain what is owed, then watch for stray beats
    while (pixel_exp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d spans (%0d empty, %0d single-point, %0d cut to %0d pixels)",
             spans_sent, empty_spans, point_spans, cut_spans, MaxSpan);
    $display("Checked %0d pixel beats under bursty requests and stalls, %0d mismatches",
             beats_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== rgba_span_interpolator_core.f =====
rtl/rsi_pkg.sv
rtl/rsi_if.sv
rtl/rsi_lane.sv
rtl/rsi_merge.sv
rtl/rgba_span_interpolator_core.sv
tb/testbench.sv
